>>> design/crtcap_pkg.sv
// Shared types and constants for the display port block with text capture.
`timescale 1ns / 1ps

package crtcap_pkg;

  typedef enum logic [1:0] {
    CMD_PORT_READ     = 2'd0,
    CMD_PORT_WRITE    = 2'd1,
    CMD_CAPTURE_READ  = 2'd2,
    CMD_CAPTURE_CLEAR = 2'd3
  } command_t;

  typedef enum logic [1:0] {
    PORT_STATUS = 2'd0,
    PORT_DATA   = 2'd1,
    PORT_UNUSED = 2'd2,
    PORT_CHAR   = 2'd3
  } port_t;

  localparam int unsigned ADDR_W = 11;
  localparam int unsigned SEL_W  = 5;

  localparam logic [SEL_W-1:0] REG_SELECT_MASK = 5'h1F;
  localparam logic [SEL_W-1:0] REG_ADDR_HI     = 5'h12;
  localparam logic [SEL_W-1:0] REG_ADDR_LO     = 5'h13;

  localparam logic [7:0] STATUS_READY   = 8'h80;
  localparam logic [7:0] CHAR_PORT_READ = 8'h20;

  localparam logic [7:0] CH_BEL      = 8'h07;
  localparam logic [7:0] CH_BS       = 8'h08;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_PRINT_LO = 8'h21;
  localparam logic [7:0] CH_DEL      = 8'h7F;

  typedef struct packed {
    command_t   command;
    port_t      port_number;
    logic [7:0] write_value;
    logic [7:0] capture_index;
  } item_t;

  // Item held in the input register and whether it retires this cycle.
  typedef struct packed {
    logic  advance;
    item_t item;
  } step_t;

endpackage

>>> design/crt_port_text_capture_top.sv
// Top level of the display controller port block with text capture.
`timescale 1ns / 1ps

// Four-port display controller register block with a character capture buffer.
// One item is accepted per clock while the input is not stalled. An item sits in
// the input register, where a short decode against the current state produces its
// result, which is loaded into the result register together with the state update
// and offered from there. A stalled result holds the item in the
// input register, which then stalls the input. The buffer is a single-port-write
// memory with a registered read at the capture index, addressed when the item is
// taken. Buffer contents are undefined after reset and need no clearing pass:
// only entries below the fill count are ever returned.
module crt_port_text_capture_top
  import crtcap_pkg::*;
#(
  parameter int unsigned CAPTURE_DEPTH = 256,
  parameter int unsigned COUNT_W       = $clog2(CAPTURE_DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               request_valid,
  output logic               request_stall,
  input  logic [1:0]         command,
  input  logic [1:0]         port_number,
  input  logic [7:0]         write_value,
  input  logic [7:0]         capture_index,
  output logic               result_valid,
  input  logic               result_stall,
  output logic [7:0]         read_value,
  output logic               echo_valid,
  output logic [7:0]         echo_char,
  output logic [COUNT_W-1:0] captured_count,
  output logic [ADDR_W-1:0]  address_now,
  output logic               attribute_now
);

  logic               s1_valid;
  item_t              s1_item;
  step_t              step;
  logic               accept;
  logic [7:0]         port_read;
  logic [7:0]         capture_read;
  logic               cap_echo_valid;
  logic [7:0]         cap_echo_char;
  logic [COUNT_W-1:0] fill_next;
  logic [ADDR_W-1:0]  address_next;
  logic               attribute_next;
  logic               attribute_state;
  logic [7:0]         read_next;

  assign step.advance   = s1_valid && (!result_valid || !result_stall);
  assign step.item      = s1_item;
  assign request_stall  = s1_valid && !step.advance;
  assign accept         = request_valid && !request_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (step.advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item.command       <= command_t'(command);
      s1_item.port_number   <= port_t'(port_number);
      s1_item.write_value   <= write_value;
      s1_item.capture_index <= capture_index;
    end
  end

  crtcap_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .step           (step),
    .port_read      (port_read),
    .address_next   (address_next),
    .attribute_next (attribute_next),
    .attribute      (attribute_state)
  );

  crtcap_capture #(
    .DEPTH (CAPTURE_DEPTH),
    .CW    (COUNT_W)
  ) u_capture (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .attribute    (attribute_state),
    .accept       (accept),
    .accept_index (capture_index),
    .capture_read (capture_read),
    .echo_valid   (cap_echo_valid),
    .echo_char    (cap_echo_char),
    .fill_next    (fill_next)
  );

  always_comb begin
    case (s1_item.command)
      CMD_PORT_READ:    read_next = port_read;
      CMD_CAPTURE_READ: read_next = capture_read;
      default:          read_next = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (step.advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step.advance) begin
      read_value     <= read_next;
      echo_valid     <= cap_echo_valid;
      echo_char      <= cap_echo_char;
      captured_count <= fill_next;
      address_now    <= address_next;
      attribute_now  <= attribute_next;
    end
  end

endmodule

>>> design/crtcap_ctrl.sv
// Register file, register select, video address and attribute flag.
`timescale 1ns / 1ps

module crtcap_ctrl
  import crtcap_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  step_t             step,
  output logic [7:0]        port_read,
  output logic [ADDR_W-1:0] address_next,
  output logic              attribute_next,
  output logic              attribute
);

  logic [SEL_W-1:0]  sel;
  logic [SEL_W-1:0]  sel_next;
  logic [7:0]        rf [32];
  logic [ADDR_W-1:0] address;
  logic              is_write;
  logic [7:0]        hi;
  logic [7:0]        lo;

  assign is_write = (step.item.command == CMD_PORT_WRITE);

  always_comb begin
    case (step.item.port_number)
      PORT_STATUS: port_read = STATUS_READY;
      PORT_DATA:   port_read = rf[sel];
      PORT_UNUSED: port_read = 8'h00;
      PORT_CHAR:   port_read = CHAR_PORT_READ;
      default:     port_read = 8'h00;
    endcase
  end

  always_comb begin
    hi = (sel == REG_ADDR_HI) ? step.item.write_value : rf[REG_ADDR_HI];
    lo = (sel == REG_ADDR_LO) ? step.item.write_value : rf[REG_ADDR_LO];
    sel_next       = sel;
    address_next   = address;
    attribute_next = attribute;
    if (is_write) begin
      case (step.item.port_number)
        PORT_STATUS: sel_next = step.item.write_value[SEL_W-1:0] & REG_SELECT_MASK;
        PORT_DATA: begin
          if (sel == REG_ADDR_HI || sel == REG_ADDR_LO) begin
            address_next   = {hi[2:0], lo};
            attribute_next = hi[3];
          end
        end
        PORT_CHAR:   address_next = address + ADDR_W'(1);
        default:     ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sel       <= '0;
      rf        <= '{default: '0};
      address   <= '0;
      attribute <= 1'b0;
    end else if (step.advance) begin
      sel       <= sel_next;
      address   <= address_next;
      attribute <= attribute_next;
      if (is_write && step.item.port_number == PORT_DATA) begin
        rf[sel] <= step.item.write_value;
      end
    end
  end

endmodule

>>> design/crtcap_capture.sv
// Character filter, capture buffer memory and fill count.
`timescale 1ns / 1ps

module crtcap_capture
  import crtcap_pkg::*;
#(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned CW    = 9
) (
  input  logic          clk,
  input  logic          rst,
  input  step_t         step,
  input  logic          attribute,
  input  logic          accept,
  input  logic [7:0]    accept_index,
  output logic [7:0]    capture_read,
  output logic          echo_valid,
  output logic [7:0]    echo_char,
  output logic [CW-1:0] fill_next
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned XW = (CW > 8) ? CW : 8;

  logic [7:0]    mem [DEPTH];
  logic [7:0]    mem_q;
  logic          bypass_hit;
  logic [7:0]    bypass_data;
  logic [CW-1:0] fill;
  logic          after_printable;
  logic          ap_next;
  logic          store;
  logic          push;
  logic [7:0]    ch;
  logic [7:0]    stored;
  logic          char_write;
  logic [XW-1:0] index_ext;
  logic [XW-1:0] fill_ext;
  logic [XW-1:0] accept_ext;
  logic [AW-1:0] write_addr;
  logic [AW-1:0] read_addr;

  assign ch         = step.item.write_value;
  assign char_write = (step.item.command == CMD_PORT_WRITE) &&
                      (step.item.port_number == PORT_CHAR);

  always_comb begin
    store   = 1'b0;
    stored  = 8'h00;
    ap_next = after_printable;
    if (char_write && !attribute) begin
      if (ch == CH_CR || ch == CH_LF) begin
        store   = 1'b1;
        stored  = CH_LF;
        ap_next = 1'b0;
      end else if (ch == CH_BS) begin
        store   = 1'b1;
        stored  = CH_BS;
        ap_next = 1'b0;
      end else if (ch == CH_BEL) begin
        store = 1'b0;
      end else if (ch == CH_SPACE) begin
        // keep a space only right after a printable
        store   = after_printable;
        stored  = CH_SPACE;
        ap_next = 1'b0;
      end else if (ch >= CH_PRINT_LO && ch < CH_DEL) begin
        store   = 1'b1;
        stored  = ch;
        ap_next = 1'b1;
      end
    end
  end

  assign push       = store && (fill < CW'(DEPTH));
  assign echo_valid = push;
  assign echo_char  = push ? stored : 8'h00;

  always_comb begin
    if (step.item.command == CMD_CAPTURE_CLEAR) begin
      fill_next = '0;
    end else if (push) begin
      fill_next = fill + CW'(1);
    end else begin
      fill_next = fill;
    end
  end

  assign index_ext    = XW'(step.item.capture_index);
  assign fill_ext     = XW'(fill);
  assign capture_read = (index_ext < fill_ext) ? (bypass_hit ? bypass_data : mem_q) : 8'h00;

  assign accept_ext = XW'(accept_index);
  assign read_addr  = accept_ext[AW-1:0];
  assign write_addr = fill_ext[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      fill            <= '0;
      after_printable <= 1'b0;
    end else if (step.advance) begin
      fill            <= fill_next;
      after_printable <= ap_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step.advance && push) begin
      mem[write_addr] <= stored;
    end
  end

  // Forward a byte written at the same edge as the read of that entry.
  always_ff @(posedge clk) begin
    if (accept) begin
      mem_q       <= mem[read_addr];
      bypass_hit  <= step.advance && push && (write_addr == read_addr);
      bypass_data <= stored;
    end
  end

endmodule

>>> design/crtcap_checker.sv
// Port-level checks for the display port block, bound to the top level.
`timescale 1ns / 1ps

module crtcap_checker
  import crtcap_pkg::*;
#(
  parameter int unsigned CAPTURE_DEPTH = 256,
  parameter int unsigned COUNT_W       = $clog2(CAPTURE_DEPTH + 1)
) (
  input logic               clk,
  input logic               rst,
  input logic               request_stall,
  input logic               result_valid,
  input logic               result_stall,
  input logic [7:0]         read_value,
  input logic               echo_valid,
  input logic [7:0]         echo_char,
  input logic [COUNT_W-1:0] captured_count,
  input logic [ADDR_W-1:0]  address_now,
  input logic               attribute_now
);

  // Nothing pending and no stall right after reset.
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !result_valid && !request_stall)
    else $error("result or stall active after reset");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(read_value) &&
      $stable(echo_char) && $stable(captured_count) && $stable(address_now))
    else $error("stalled result changed");

  // An echoed character never comes from the attribute plane and fills the buffer.
  a_echo_consistent: assert property (@(posedge clk) disable iff (rst)
    result_valid && echo_valid |-> !attribute_now && echo_char != 8'h00 &&
      captured_count != '0)
    else $error("echo inconsistent with plane or fill");

  a_fill_bounded: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> captured_count <= COUNT_W'(CAPTURE_DEPTH) &&
      (echo_valid || echo_char == 8'h00))
    else $error("fill count over depth or stray echo character");

endmodule

bind crt_port_text_capture_top crtcap_checker #(
  .CAPTURE_DEPTH (CAPTURE_DEPTH),
  .COUNT_W       (COUNT_W)
) u_crtcap_checker (.*);

>>> verif/tb_top.sv
// Self-checking testbench for the display port block with text capture.
`timescale 1ns / 1ps

module tb_top;
  import crtcap_pkg::*;

  localparam int unsigned DEPTH      = 256;
  localparam int unsigned IDLE_LIMIT = 4000;
  localparam int unsigned HOLD_LEN   = 64;

  typedef struct packed {
    logic [7:0] read_value;
    logic       echo_valid;
    logic [7:0] echo_char;
    logic [8:0] captured_count;
    logic [10:0] address_now;
    logic       attribute_now;
  } port_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic       request_valid = 1'b0;
  logic       request_stall;
  logic [1:0] command       = '0;
  logic [1:0] port_number   = '0;
  logic [7:0] write_value   = '0;
  logic [7:0] capture_index = '0;
  logic       result_valid;
  logic       result_stall  = 1'b0;
  logic [7:0] read_value;
  logic       echo_valid;
  logic [7:0] echo_char;
  logic [8:0] captured_count;
  logic [10:0] address_now;
  logic       attribute_now;

  crt_port_text_capture_top #(.CAPTURE_DEPTH(DEPTH)) i_dut (
    .clk           (clk),
    .rst           (rst),
    .request_valid (request_valid),
    .request_stall (request_stall),
    .command       (command),
    .port_number   (port_number),
    .write_value   (write_value),
    .capture_index (capture_index),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .read_value    (read_value),
    .echo_valid    (echo_valid),
    .echo_char     (echo_char),
    .captured_count(captured_count),
    .address_now   (address_now),
    .attribute_now (attribute_now)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predicted block state
  logic [SEL_W-1:0]  sel_reg     = '0;
  logic [7:0]        reg_bank [32];
  logic [ADDR_W-1:0] video_addr  = '0;
  logic              attr_mode   = 1'b0;
  logic              after_print = 1'b0;
  logic [7:0]        capture_mem [DEPTH];
  logic [8:0]        capture_fill = '0;

  port_result_t results_due[$];

  int unsigned errors        = 0;
  int unsigned items_taken   = 0;
  int unsigned results_seen  = 0;
  int unsigned echoes_seen   = 0;
  int unsigned peak_fill     = 0;
  int unsigned input_stalls  = 0;
  int unsigned quiet_cycles  = 0;
  bit          idle_on       = 1'b1;
  bit          hold_request  = 1'b0;

  initial begin
    foreach (reg_bank[i]) reg_bank[i] = '0;
  end

  task automatic predict_access(input item_t it, output port_result_t r);
    logic [7:0] c;
    logic [7:0] kept;
    logic       keep;
    r = '0;
    c = it.write_value;
    case (it.command)
      CMD_PORT_READ: begin
        case (it.port_number)
          PORT_STATUS: r.read_value = STATUS_READY;
          PORT_DATA:   r.read_value = reg_bank[sel_reg];
          PORT_UNUSED: r.read_value = '0;
          PORT_CHAR:   r.read_value = CHAR_PORT_READ;
          default:     ;
        endcase
      end
      CMD_PORT_WRITE: begin
        case (it.port_number)
          PORT_STATUS: sel_reg = c[SEL_W-1:0] & REG_SELECT_MASK;
          PORT_DATA: begin
            reg_bank[sel_reg] = c;
            if (sel_reg == REG_ADDR_HI || sel_reg == REG_ADDR_LO) begin
              attr_mode  = reg_bank[REG_ADDR_HI][3];
              video_addr = {reg_bank[REG_ADDR_HI][2:0], reg_bank[REG_ADDR_LO]};
            end
          end
          PORT_UNUSED: ;
          PORT_CHAR: begin
            keep = 1'b0;
            kept = '0;
            if (!attr_mode) begin
              if (c == CH_CR || c == CH_LF) begin
                kept = CH_LF;
                keep = 1'b1;
                after_print = 1'b0;
              end else if (c == CH_BS) begin
                kept = CH_BS;
                keep = 1'b1;
                after_print = 1'b0;
              end else if (c == CH_BEL) begin
              end else if (c == CH_SPACE) begin
                keep = after_print;
                kept = CH_SPACE;
                after_print = 1'b0;
              end else if (c >= CH_PRINT_LO && c < CH_DEL) begin
                kept = c;
                keep = 1'b1;
                after_print = 1'b1;
              end
              // full buffer: drop the character, the flag update above still holds
              if (keep && capture_fill < DEPTH) begin
                capture_mem[capture_fill[7:0]] = kept;
                capture_fill = capture_fill + 1'b1;
                r.echo_valid = 1'b1;
                r.echo_char  = kept;
              end
            end
            video_addr = video_addr + 1'b1;
          end
          default: ;
        endcase
      end
      CMD_CAPTURE_READ: begin
        if ({1'b0, it.capture_index} < capture_fill) r.read_value = capture_mem[it.capture_index];
      end
      CMD_CAPTURE_CLEAR: capture_fill = '0;
      default: ;
    endcase
    r.captured_count = capture_fill;
    r.address_now    = video_addr;
    r.attribute_now  = attr_mode;
  endtask

  task automatic check_field(input string field, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected 0x%0h, got 0x%0h", $time, field, want, got);
    end
  endtask

  // Predict on each accepted item, check each accepted result, watch for a hang
  always @(posedge clk) begin
    item_t        it;
    port_result_t want;
    bit           moved;
    if (!rst) begin
      moved = 1'b0;
      if (request_valid && request_stall) input_stalls++;
      if (request_valid && !request_stall) begin
        it.command       = command_t'(command);
        it.port_number   = port_t'(port_number);
        it.write_value   = write_value;
        it.capture_index = capture_index;
        predict_access(it, want);
        results_due.push_back(want);
        if (capture_fill > peak_fill) peak_fill = capture_fill;
        items_taken++;
        moved = 1'b1;
      end
      if (result_valid && !result_stall) begin
        moved = 1'b1;
        results_seen++;
        if (echo_valid === 1'b1) echoes_seen++;
        if (results_due.size() == 0) begin
          errors++;
          $display("%0t: result with none expected, read_value 0x%0h", $time, read_value);
        end else begin
          want = results_due.pop_front();
          check_field("read_value", want.read_value, read_value);
          check_field("echo_valid", want.echo_valid, echo_valid);
          check_field("echo_char", want.echo_char, echo_char);
          check_field("captured_count", want.captured_count, captured_count);
          check_field("address_now", want.address_now, address_now);
          check_field("attribute_now", want.attribute_now, attribute_now);
        end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
        $display("FAIL");
        $finish;
      end
    end
  end

  // Result side: random stall bursts, plus one long hold on request
  always @(negedge clk) begin
    int unsigned stall_left;
    int unsigned hold_left;
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left = HOLD_LEN;
    end
    if (hold_left != 0) begin
      result_stall <= 1'b1;
      hold_left--;
    end else if (stall_left != 0) begin
      result_stall <= 1'b1;
      stall_left--;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      result_stall <= 1'b1;
      stall_left = $urandom_range(1, 8) - 1;
    end else begin
      result_stall <= 1'b0;
    end
  end

  // Offer one item and hold it until taken; enter and leave on a falling edge
  task automatic send_access(input command_t cmd, input port_t port,
                             input logic [7:0] value, input logic [7:0] index);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      request_valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    command       = cmd;
    port_number   = port;
    write_value   = value;
    capture_index = index;
    request_valid = 1'b1;
    @(posedge clk);
    while (request_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_char(input logic [7:0] c);
    send_access(CMD_PORT_WRITE, PORT_CHAR, c, 8'($urandom));
  endtask

  task automatic write_register(input logic [SEL_W-1:0] idx, input logic [7:0] value);
    send_access(CMD_PORT_WRITE, PORT_STATUS, {3'($urandom), idx}, 8'($urandom));
    send_access(CMD_PORT_WRITE, PORT_DATA, value, 8'($urandom));
  endtask

  function automatic logic [7:0] random_char();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 8'($urandom_range(CH_PRINT_LO, CH_DEL - 1));
    if (pick < 70) return CH_SPACE;
    if (pick < 76) return CH_CR;
    if (pick < 80) return CH_LF;
    if (pick < 84) return CH_BS;
    if (pick < 87) return CH_BEL;
    return 8'($urandom);
  endfunction

  task automatic send_random_access();
    int unsigned pick;
    logic [7:0]  hi;
    logic [7:0]  idx;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      send_char(random_char());
    end else if (pick < 56) begin
      // load a new video address, mostly on the character plane
      hi = 8'($urandom);
      if ($urandom_range(0, 4) != 0) hi[3] = 1'b0;
      write_register(REG_ADDR_HI, hi);
      write_register(REG_ADDR_LO, 8'($urandom));
    end else if (pick < 64) begin
      send_access(CMD_PORT_WRITE, port_t'($urandom_range(0, 2)), 8'($urandom), 8'($urandom));
    end else if (pick < 74) begin
      send_access(CMD_PORT_READ, port_t'($urandom), 8'($urandom), 8'($urandom));
    end else if (pick < 90) begin
      if (capture_fill != 0 && $urandom_range(0, 3) != 0)
        idx = 8'($urandom_range(0, (capture_fill > 255) ? 255 : capture_fill));
      else
        idx = 8'($urandom);
      send_access(CMD_CAPTURE_READ, port_t'($urandom), 8'($urandom), idx);
    end else if (pick < 92) begin
      send_access(CMD_CAPTURE_CLEAR, port_t'($urandom), 8'($urandom), 8'($urandom));
    end else begin
      send_access(command_t'($urandom), port_t'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  task automatic test_directed();
    send_access(CMD_PORT_READ, PORT_STATUS, 8'hFF, 8'hFF);
    send_access(CMD_PORT_READ, PORT_DATA, 8'h00, 8'h00);
    send_access(CMD_PORT_READ, PORT_UNUSED, 8'hFF, 8'hFF);
    send_access(CMD_PORT_READ, PORT_CHAR, 8'h00, 8'h00);
    // select the last register through a masked write, then read it back
    write_register(5'h1F, 8'hFF);
    send_access(CMD_PORT_READ, PORT_DATA, 8'h00, 8'h00);
    // highest address on the attribute plane, then a character that wraps it
    write_register(REG_ADDR_HI, 8'h0F);
    write_register(REG_ADDR_LO, 8'hFF);
    send_char("A");
    write_register(REG_ADDR_HI, 8'h00);
    send_char("A");
    send_char(CH_SPACE);
    send_char(CH_SPACE);
    send_char(CH_CR);
    send_char(CH_LF);
    send_char(CH_BS);
    send_char(CH_BEL);
    send_char(CH_DEL);
    send_char(8'hFF);
    send_char("~");
    send_access(CMD_PORT_WRITE, PORT_UNUSED, 8'hFF, 8'hFF);
    send_access(CMD_CAPTURE_READ, PORT_STATUS, 8'h00, 8'h00);
    send_access(CMD_CAPTURE_READ, PORT_STATUS, 8'h00, 8'd200);
    send_access(CMD_CAPTURE_CLEAR, PORT_CHAR, 8'hFF, 8'hFF);
    send_access(CMD_CAPTURE_READ, PORT_STATUS, 8'h00, 8'h00);
  endtask

  task automatic test_full_buffer();
    write_register(REG_ADDR_HI, 8'h00);
    send_access(CMD_CAPTURE_CLEAR, PORT_STATUS, 8'h00, 8'h00);
    send_char(CH_CR);
    repeat (DEPTH + 10) begin
      if ($urandom_range(0, 5) == 0) send_char(CH_SPACE);
      else send_char(8'($urandom_range(CH_PRINT_LO, CH_DEL - 1)));
    end
    send_char(CH_LF);
    // dropped on a full buffer, but it still arms the space that follows
    send_char("Z");
    send_access(CMD_CAPTURE_READ, PORT_STATUS, 8'h00, 8'hFF);
    send_access(CMD_CAPTURE_READ, PORT_STATUS, 8'h00, 8'h00);
    send_access(CMD_CAPTURE_CLEAR, PORT_STATUS, 8'h00, 8'h00);
    send_char(CH_SPACE);
    send_access(CMD_CAPTURE_READ, PORT_STATUS, 8'h00, 8'h00);
  endtask

  task automatic test_backpressure();
    hold_request = 1'b1;
    repeat (40) send_random_access();
  endtask

  task automatic test_random_traffic(input int unsigned count);
    repeat (count) send_random_access();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_full_buffer();
    test_random_traffic(500);
    test_backpressure();
    test_random_traffic(500);
    idle_on = 1'b0;
    test_random_traffic(250);

    request_valid = 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d items and checked %0d results; %0d characters echoed.",
             items_taken, results_seen, echoes_seen);
    $display("Capture peaked at %0d entries; input held off for %0d cycles.",
             peak_fill, input_stalls);
    if (errors == 0 && results_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
